FILE: sv/srb_pkg.sv
// Shared types, constants and the shift table of the shifted Rosenbrock evaluator.
`default_nettype none

package srb_pkg;

  localparam int unsigned TABLE_LEN   = 100;
  localparam int unsigned MAX_DIM_DEF = 100;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned X_W         = 16;
  localparam int unsigned Z_W         = 17;
  localparam int unsigned SUM_W       = 63;

  // z = floor(N / 800) - 51200 with N = 625*x - 2048*s + Z_OFS (always positive).
  localparam int unsigned Z_OFS       = 20480400;
  localparam int unsigned Z_BIAS      = 51200;
  // Reciprocal of 25 scaled by 2^27, exact for dividends below 2^22.
  localparam int unsigned RECIP25     = 5368710;

  // Shifts in hundredths.
  localparam logic signed [15:0] SHIFT_TAB [TABLE_LEN] = '{
    16'sd5234, -16'sd8534, -16'sd5021, 16'sd5620, 16'sd8955,
    16'sd1007, -16'sd6364, -16'sd7790, 16'sd6673, 16'sd6445,
    -16'sd9851, -16'sd5152, -16'sd4199, -16'sd1725, 16'sd4874,
    -16'sd4486, -16'sd8700, 16'sd4813, 16'sd3018, -16'sd5353,
    16'sd3049, 16'sd9269, 16'sd1046, 16'sd5201, 16'sd4530,
    -16'sd8743, 16'sd46, -16'sd7161, 16'sd2569, -16'sd4987,
    -16'sd7486, -16'sd804, -16'sd943, 16'sd378, 16'sd8261,
    -16'sd5776, 16'sd1160, -16'sd7107, 16'sd9942, -16'sd1139,
    16'sd7325, 16'sd8424, 16'sd2230, 16'sd4972, 16'sd486,
    -16'sd5332, 16'sd9837, -16'sd9625, 16'sd9665, 16'sd3724,
    16'sd7270, 16'sd9584, 16'sd2633, 16'sd6258, 16'sd1686,
    -16'sd8687, -16'sd9032, 16'sd2812, 16'sd2044, -16'sd652,
    16'sd9874, -16'sd6042, 16'sd448, 16'sd6453, 16'sd789,
    16'sd2154, -16'sd537, 16'sd3311, -16'sd1098, -16'sd3308,
    16'sd3487, 16'sd87, -16'sd93, 16'sd2294, 16'sd5597,
    16'sd200, 16'sd4327, -16'sd9482, -16'sd5226, -16'sd6553,
    16'sd3072, -16'sd5408, -16'sd7803, 16'sd4236, -16'sd8716,
    -16'sd8526, -16'sd777, 16'sd5121, 16'sd3854, 16'sd2773,
    16'sd331, 16'sd2261, 16'sd8726, 16'sd7041, -16'sd5751,
    -16'sd1936, 16'sd3378, -16'sd9223, -16'sd3592, -16'sd5391
  };

  function automatic logic signed [15:0] shift_of(input logic [IDX_W-1:0] idx);
    logic signed [15:0] s;
    s = 16'sd0;
    if (32'(idx) < TABLE_LEN) begin
      s = SHIFT_TAB[idx];
    end
    return s;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CALC_N,
    OP_MUL_Z,
    OP_SET_Z,
    OP_DSQ,
    OP_PART2,
    OP_ACC,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic first;
    logic last;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/srb_ctrl.sv
// Sequencer that steps the datapath through the per-word evaluation.
`default_nettype none

module srb_ctrl
  import srb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t sts_i,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC_N,
    ST_MUL_Z,
    ST_SET_Z,
    ST_DSQ,
    ST_PART2,
    ST_ACC,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          // A word past MAX_DIM only marks the overrun.
          state_d  = sts_i.full ? ST_FINISH : ST_CALC_N;
        end
      end
      ST_CALC_N: begin
        cmd_o.op = OP_CALC_N;
        state_d  = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd_o.op = OP_MUL_Z;
        state_d  = ST_SET_Z;
      end
      ST_SET_Z: begin
        cmd_o.op = OP_SET_Z;
        if (sts_i.first) begin
          state_d = sts_i.last ? ST_FINISH : ST_IDLE;
        end else begin
          state_d = ST_DSQ;
        end
      end
      ST_DSQ: begin
        cmd_o.op = OP_DSQ;
        state_d  = ST_PART2;
      end
      ST_PART2: begin
        cmd_o.op = OP_PART2;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = sts_i.last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (!sts_i.last) begin
          state_d = ST_IDLE;
        end else if (!sts_i.out_blocked) begin
          cmd_o.op = OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/srb_dp.sv
// Datapath: shift mapping, one shared multiplier, saturating sum and result register.
`default_nettype none

module srb_dp
  import srb_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               sts_o,
  input  wire logic [X_W-1:0]   x_code_i,
  input  wire logic             is_last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [SUM_W-1:0]      objective_q8_o,
  output logic                  saturated_o,
  output logic                  too_long_o
);

  // Control state, cleared at reset; all but last_q and out_valid_q also clear at the end of each vector.
  logic [IDX_W-1:0]      idx_q;
  logic signed [Z_W-1:0] prev_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  sat_q;
  logic                  ovr_q;
  logic                  last_q;
  logic                  out_valid_q;

  // Working registers.
  logic [X_W-1:0]        x_q;
  logic [26:0]           n_q;
  logic [63:0]           p_q;
  logic signed [Z_W-1:0] z_q;
  logic [46:0]           t1_q;
  logic [SUM_W-1:0]      obj_q;
  logic                  sat_out_q;
  logic                  ovr_out_q;

  logic signed [27:0]    ofs;
  logic [26:0]           n_d;
  logic signed [Z_W-1:0] z_d;
  logic [Z_W:0]          z_ext;
  logic signed [33:0]    d;
  logic [33:0]           d_abs;
  logic [Z_W-1:0]        prev_abs;
  logic signed [Z_W:0]   w;
  logic [Z_W:0]          w_abs;
  logic [31:0]           op_a;
  logic [31:0]           op_b;
  logic [63:0]           mul;
  logic [70:0]           prod100;
  logic [47:0]           term;
  logic [63:0]           sum_new;

  assign sts_o.full        = (idx_q == IDX_W'(MAX_DIM));
  assign sts_o.first       = (idx_q == '0);
  assign sts_o.last        = last_q;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  // N = 625*x - 2048*s + offset, positive for every code and table entry.
  always_comb begin
    ofs = 28'(Z_OFS) - (28'(shift_of(idx_q)) <<< 11);
    n_d = 27'({x_q, 9'b0}) + 27'({x_q, 6'b0}) + 27'({x_q, 5'b0})
          + 27'({x_q, 4'b0}) + 27'(x_q) + ofs[26:0];
  end

  // The product holds floor(N/32) * recip25; its top bits give floor(N/800).
  always_comb begin
    z_ext = p_q[44:27] - (Z_W+1)'(Z_BIAS);
    z_d   = z_ext[Z_W-1:0];
  end

  always_comb begin
    d        = (34'(z_q) <<< 8) - $signed({2'b00, p_q[31:0]});
    d_abs    = d[33] ? 34'(-d) : 34'(d);
    prev_abs = prev_q[Z_W-1] ? Z_W'(-prev_q) : Z_W'(prev_q);
    w        = (Z_W+1)'(256) - (Z_W+1)'(prev_q);
    w_abs    = w[Z_W] ? (Z_W+1)'(-w) : (Z_W+1)'(w);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      OP_MUL_Z: begin
        op_a = 32'(n_q[26:5]);
        op_b = 32'(RECIP25);
      end
      OP_SET_Z: begin
        op_a = 32'(prev_abs);
        op_b = 32'(prev_abs);
      end
      OP_DSQ: begin
        op_a = d_abs[31:0];
        op_b = d_abs[31:0];
      end
      OP_PART2: begin
        op_a = 32'(w_abs);
        op_b = 32'(w_abs);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul = {32'b0, op_a} * {32'b0, op_b};
  end

  // 100 * d^2 by shifts; the Q8 value is the product without its low 24 bits.
  always_comb begin
    prod100 = (71'(p_q) << 6) + (71'(p_q) << 5) + (71'(p_q) << 2);
    term    = 48'(t1_q) + 48'(p_q[47:8]);
    sum_new = 64'(sum_q) + 64'(term);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q <= x_code_i;
      end
      OP_CALC_N: begin
        n_q <= n_d;
      end
      OP_MUL_Z, OP_SET_Z, OP_DSQ: begin
        p_q <= mul;
        if (cmd_i.op == OP_SET_Z) begin
          z_q <= z_d;
        end
      end
      OP_PART2: begin
        p_q  <= mul;
        t1_q <= prod100[70:24];
      end
      OP_FINISH: begin
        obj_q     <= sum_q;
        sat_out_q <= sat_q;
        ovr_out_q <= ovr_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      ovr_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          last_q <= is_last_i;
          if (sts_o.full) begin
            ovr_q <= 1'b1;
          end
        end
        OP_SET_Z: begin
          if (sts_o.first) begin
            prev_q <= z_d;
            idx_q  <= idx_q + IDX_W'(1);
          end
        end
        OP_ACC: begin
          prev_q <= z_q;
          idx_q  <= idx_q + IDX_W'(1);
          if (sum_new[63]) begin
            sum_q <= '1;
            sat_q <= 1'b1;
          end else begin
            sum_q <= sum_new[SUM_W-1:0];
          end
        end
        OP_FINISH: begin
          idx_q       <= '0;
          prev_q      <= '0;
          sum_q       <= '0;
          sat_q       <= 1'b0;
          ovr_q       <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign objective_q8_o = obj_q;
  assign saturated_o    = sat_out_q;
  assign too_long_o     = ovr_out_q;

endmodule

`default_nettype wire

FILE: sv/shifted_rosenbrock_eval.sv
// Shifted Rosenbrock evaluator: one vector element per word, one result per vector.
// The input stalls while an element is in work. The single shared 32x32 multiplier
// serves the shift division and three squares. After an element marked last, the sum
// enters the output register once no pending output word is stalled. An element past
// MAX_DIM only marks the overrun. Reset (asynchronous, active low) clears the sum, the
// flags and the element count and drops any pending output word.
`default_nettype none

module shifted_rosenbrock_eval
  import srb_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [X_W-1:0]   x_code_i,
  input  wire logic             is_last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [SUM_W-1:0]      objective_q8_o,
  output logic                  saturated_o,
  output logic                  too_long_o
);

  cmd_t    cmd;
  status_t sts;

  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srb_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .x_code_i       (x_code_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .objective_q8_o (objective_q8_o),
    .saturated_o    (saturated_o),
    .too_long_o     (too_long_o)
  );

endmodule

`default_nettype wire

FILE: tb/shifted_rosenbrock_eval_tb.sv
// Self-checking testbench for the shifted Rosenbrock evaluator with randomized flow control.
module shifted_rosenbrock_eval_tb;
  import srb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int VECTOR_LIMIT   = 100;
  localparam logic [63:0] SUM_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [SUM_W-1:0] objective;
    logic             clipped;
    logic             overrun;
  } result_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic           last;
    logic           typed;
    result_t        res;
  } row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  localparam result_t ZERO_RESULT = '0;

  // Single-element vectors have no pairs, so their sum is zero.
  localparam int DIRECTED_LEN = 19;
  localparam row_t DIRECTED [DIRECTED_LEN] = '{
    '{16'h0000, 1'b1, 1'b1, ZERO_RESULT},
    '{16'hFFFF, 1'b1, 1'b1, ZERO_RESULT},
    '{16'h8000, 1'b1, 1'b1, ZERO_RESULT},
    '{16'h0000, 1'b0, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b1, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h0000, 1'b1, 1'b0, ZERO_RESULT},
    '{16'h0000, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h0000, 1'b1, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b0, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b1, 1'b0, ZERO_RESULT},
    '{16'h1234, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h8000, 1'b0, 1'b0, ZERO_RESULT},
    '{16'hAAAA, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h5555, 1'b1, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h0000, 1'b0, 1'b0, ZERO_RESULT},
    '{16'hFFFF, 1'b0, 1'b0, ZERO_RESULT},
    '{16'h0000, 1'b1, 1'b0, ZERO_RESULT}
  };

  // Per-position shifts in hundredths.
  localparam int SHIFT_HUNDREDTHS [100] = '{
    5234, -8534, -5021, 5620, 8955, 1007, -6364, -7790, 6673, 6445,
    -9851, -5152, -4199, -1725, 4874, -4486, -8700, 4813, 3018, -5353,
    3049, 9269, 1046, 5201, 4530, -8743, 46, -7161, 2569, -4987,
    -7486, -804, -943, 378, 8261, -5776, 1160, -7107, 9942, -1139,
    7325, 8424, 2230, 4972, 486, -5332, 9837, -9625, 9665, 3724,
    7270, 9584, 2633, 6258, 1686, -8687, -9032, 2812, 2044, -652,
    9874, -6042, 448, 6453, 789, 2154, -537, 3311, -1098, -3308,
    3487, 87, -93, 2294, 5597, 200, 4327, -9482, -5226, -6553,
    3072, -5408, -7803, 4236, -8716, -8526, -777, 5121, 3854, 2773,
    331, 2261, 8726, 7041, -5751, -1936, 3378, -9223, -3592, -5391
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [X_W-1:0]   x_code_i = '0;
  logic             is_last_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [SUM_W-1:0] objective_q8_o;
  logic             saturated_o;
  logic             too_long_o;

  shifted_rosenbrock_eval dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_code_i       (x_code_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .objective_q8_o (objective_q8_o),
    .saturated_o    (saturated_o),
    .too_long_o     (too_long_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state for the vector in progress.
  int                    elem_count = 0;
  logic signed [Z_W-1:0] prev_z = '0;
  logic [63:0]           acc_sum = '0;
  logic                  acc_clipped = 1'b0;
  logic                  acc_overrun = 1'b0;

  result_t pending_sums [$];
  result_t oldest;
  int errors = 0;
  int elements_sent = 0;
  int vectors_done = 0;
  int overrun_vectors = 0;
  int longest_vector = 0;
  int words_in_vector = 0;
  int results_seen = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int rx_seg_left = 0;
  rx_mode_e rx_mode = RX_OPEN;

  // z = round(256*(200*x/65536 - 100 - s/100)) in signed Q8, halves rounded up.
  function automatic logic signed [Z_W-1:0] shifted_q8(logic [X_W-1:0] x, int pos);
    longint s;
    longint num;
    longint biased;
    s = (pos < 100) ? longint'(SHIFT_HUNDREDTHS[pos]) : 64'sd0;
    num = 64'sd5000 * longint'(x) - 64'sd163840000 - 64'sd16384 * s;
    biased = num + 64'sd640000000 + 64'sd3200;
    return Z_W'(biased / 64'sd6400 - 64'sd100000);
  endfunction

  // Q8 of 100*(zn - z^2)^2 + (1 - z)^2 with each part floored.
  function automatic logic [63:0] pair_cost(logic signed [Z_W-1:0] z,
                                            logic signed [Z_W-1:0] zn);
    longint diff;
    longint w;
    logic [63:0] ad;
    logic [63:0] dsq;
    logic [63:0] aw;
    logic [63:0] part1;
    diff = longint'(zn) * 64'sd256 - longint'(z) * longint'(z);
    ad = (diff < 0) ? 64'(-diff) : 64'(diff);
    dsq = ad * ad;
    part1 = 64'd100 * (dsq >> 24) + ((64'd100 * (dsq & 64'hFF_FFFF)) >> 24);
    w = 64'sd256 - longint'(z);
    aw = (w < 0) ? 64'(-w) : 64'(w);
    return part1 + ((aw * aw) >> 8);
  endfunction

  task automatic rosenbrock_step(input logic [X_W-1:0] x, input logic last,
                                 output bit has_result, output result_t res);
    logic signed [Z_W-1:0] z;
    logic [63:0] term;
    has_result = 1'b0;
    res = ZERO_RESULT;
    if (elem_count < VECTOR_LIMIT) begin
      z = shifted_q8(x, elem_count);
      if (elem_count > 0) begin
        term = pair_cost(prev_z, z);
        if (acc_sum > SUM_CEILING || term > SUM_CEILING - acc_sum) begin
          acc_sum = SUM_CEILING;
          acc_clipped = 1'b1;
        end else begin
          acc_sum = acc_sum + term;
        end
      end
      prev_z = z;
      elem_count++;
    end else begin
      acc_overrun = 1'b1;
    end
    if (last) begin
      has_result = 1'b1;
      res = '{acc_sum[SUM_W-1:0], acc_clipped, acc_overrun};
      vectors_done++;
      if (acc_overrun) overrun_vectors++;
      elem_count = 0;
      prev_z = '0;
      acc_sum = '0;
      acc_clipped = 1'b0;
      acc_overrun = 1'b0;
    end
  endtask

  // The sender works in bursts; between bursts a random gap may lower valid.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_word(input logic [X_W-1:0] x, input logic last,
                           input logic typed, input result_t typed_res);
    bit has_result;
    result_t res;
    pace();
    in_valid_i <= 1'b1;
    x_code_i <= x;
    is_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    elements_sent++;
    words_in_vector++;
    if (last) begin
      if (words_in_vector > longest_vector) longest_vector = words_in_vector;
      words_in_vector = 0;
    end
    rosenbrock_step(x, last, has_result, res);
    if (has_result) pending_sums.push_back(typed ? typed_res : res);
  endtask

  task automatic send_vector(input int len);
    logic [X_W-1:0] x;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? '1 : '0;
      else x = X_W'($urandom_range(0, 65535));
      send_word(x, k == len - 1, 1'b0, ZERO_RESULT);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: a long hold-off on request, otherwise segments of different stall patterns.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_seg_left == 0) begin
        rx_seg_left <= $urandom_range(10, 80);
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end else begin
        rx_seg_left <= rx_seg_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_stall_i <= 1'b0;
        RX_LIGHT:  out_stall_i <= ($urandom_range(0, 99) < 30);
        RX_HEAVY:  out_stall_i <= ($urandom_range(0, 99) < 75);
        RX_TOGGLE: out_stall_i <= ~out_stall_i;
        default:   out_stall_i <= 1'b0;
      endcase
    end
  end

  // Each accepted result word is matched against the oldest predicted sum.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: objective %0d saturated %0b too_long %0b",
                 $time, objective_q8_o, saturated_o, too_long_o);
      end else begin
        oldest = pending_sums.pop_front();
        results_seen++;
        check_field("objective_q8", 64'(oldest.objective), 64'(objective_q8_o));
        check_field("saturated", 64'(oldest.clipped), 64'(saturated_o));
        check_field("too_long", 64'(oldest.overrun), 64'(too_long_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_sums.size());
      $display("shifted_rosenbrock_eval_tb: errors");
      $finish;
    end
  end

  initial begin
    int pick;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_LEN; r++) begin
      send_word(DIRECTED[r].x, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].res);
    end

    // A vector exactly at the limit, then one that runs past it.
    send_vector(VECTOR_LIMIT);
    send_vector(VECTOR_LIMIT + 3);

    while (elements_sent < ITEM_TARGET) begin
      if (vectors_done == 30) hold_requests <= hold_requests + 1;
      if (vectors_done == 60) begin
        // Let the block drain completely before carrying on.
        in_valid_i <= 1'b0;
        burst_left = 0;
        do @(posedge clk_i); while (pending_sums.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) len = 1;
      else if (pick < 70) len = $urandom_range(2, 8);
      else if (pick < 85) len = $urandom_range(9, 40);
      else if (pick < 93) len = $urandom_range(90, VECTOR_LIMIT);
      else len = $urandom_range(VECTOR_LIMIT + 1, VECTOR_LIMIT + 12);
      send_vector(len);
    end
    in_valid_i <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d vectors over %0d words, %0d results checked.",
             vectors_done, elements_sent, results_seen);
    $display("Vectors past the table: %0d, longest vector: %0d words.",
             overrun_vectors, longest_vector);
    if (errors == 0) begin
      $display("shifted_rosenbrock_eval_tb: clean");
    end else begin
      $display("shifted_rosenbrock_eval_tb: errors");
    end
    $finish;
  end

endmodule
